// File: rtl/sha256_pkg.sv
// Package: SHA-256 hasher types, constants and round functions.
package sha256_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_data;
        logic       end_of_message;
    } t_in_beat;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_beat;

    typedef struct packed {
        logic       load_byte;
        logic [7:0] load_value;
        logic       start_block;
        logic       round_en;
        logic       finish_block;
        logic       init_hash;
        logic       clear_count;
        logic       count_byte;
        logic [2:0] rd_word;
    } t_dp_cmd;

    typedef struct packed {
        logic [5:0]  fill_pos;
        logic [60:0] byte_count;
        logic [31:0] hash_word;
    } t_dp_status;

    localparam int unsigned ROUNDS = 64;
    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS = 6'd56;

    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

// File: rtl/sha256_datapath.sv
// Datapath: block buffer, schedule window, round logic, hash words, byte count.
module sha256_datapath (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  sha256_pkg::t_dp_cmd    i_cmd,
    output sha256_pkg::t_dp_status o_status
);
    import sha256_pkg::*;

    logic [31:0] r_blk [16];
    logic [31:0] r_w [16];
    logic [31:0] r_v [8];
    logic [31:0] r_h [8];
    logic [60:0] r_count;
    logic [5:0]  r_fill;
    logic [5:0]  r_round;

    logic [31:0] w15, w2, s0, s1, w_new, w_cur, t1, t2;
    logic [31:0] e, a;
    logic [4:0]  lane_lsb;

    // big-endian byte lane within the buffer word
    assign lane_lsb = {~r_fill[1:0], 3'b000};

    always_comb begin
        w15   = r_w[1];
        w2    = r_w[14];
        s0    = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
        s1    = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
        w_new = s1 + r_w[9] + s0 + r_w[0];
        w_cur = (r_round < 6'd16) ? r_w[0] : w_new;
        e     = r_v[4];
        a     = r_v[0];
        t1    = r_v[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
              + ((e & r_v[5]) ^ (~e & r_v[6])) + ROUND_K[r_round] + w_cur;
        t2    = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
              + ((a & r_v[1]) ^ (a & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    // byte buffer and fill position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_cmd.load_byte) begin
            r_blk[r_fill[5:2]][lane_lsb +: 8] <= i_cmd.load_value;
            r_fill <= r_fill + 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.clear_count) begin
            r_count <= '0;
        end else if (i_cmd.count_byte) begin
            r_count <= r_count + 61'd1;
        end
    end

    // rounds 0-15 use w[0] as current word; later w_new, from window W[r-16..r-1]
    always_ff @(posedge i_clk) begin
        if (i_cmd.start_block) begin
            for (int j = 0; j < 16; j++) begin
                r_w[j] <= r_blk[j];
            end
            for (int j = 0; j < 8; j++) begin
                r_v[j] <= r_h[j];
            end
            r_round <= '0;
        end else if (i_cmd.round_en) begin
            for (int j = 0; j < 15; j++) begin
                r_w[j] <= r_w[j+1];
            end
            r_w[15] <= (r_round < 6'd16) ? r_w[0] : w_new;
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
            r_round <= r_round + 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < 8; j++) r_h[j] <= H_INIT[j];
        end else if (i_cmd.init_hash) begin
            for (int j = 0; j < 8; j++) r_h[j] <= H_INIT[j];
        end else if (i_cmd.finish_block) begin
            for (int j = 0; j < 8; j++) r_h[j] <= r_h[j] + r_v[j];
        end
    end

    assign o_status.fill_pos   = r_fill;
    assign o_status.byte_count = r_count;
    assign o_status.hash_word  = r_h[i_cmd.rd_word];
endmodule

// File: rtl/sha256_ctrl.sv
// Controller: input handshake, padding sequence, round count, digest output.
module sha256_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  sha256_pkg::t_in_beat   i_data,
    output logic                   o_valid,
    input  logic                   i_ready,
    output sha256_pkg::t_out_beat  o_data,
    output sha256_pkg::t_dp_cmd    o_cmd,
    input  sha256_pkg::t_dp_status i_status
);
    import sha256_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_LOAD, S_ROUND, S_FINISH, S_PAD, S_OUT
    } t_state;

    t_state      r_state;
    logic        r_closing;
    logic        r_last_block;
    logic [6:0]  r_cnt;
    logic [63:0] r_bits;
    logic        r_ovalid;
    logic [2:0]  r_idx;
    logic [31:0] r_word;
    logic        r_pad_first;

    logic accept;
    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;

    always_comb begin
        o_cmd = '0;
        o_cmd.rd_word = r_idx;
        case (r_state)
            S_IDLE: begin
                if (accept && i_data.has_data) begin
                    o_cmd.load_byte  = 1'b1;
                    o_cmd.load_value = i_data.data_byte;
                    o_cmd.count_byte = 1'b1;
                end
            end
            S_LOAD:   o_cmd.start_block = 1'b1;
            S_ROUND:  o_cmd.round_en = 1'b1;
            S_FINISH: o_cmd.finish_block = 1'b1;
            S_PAD: begin
                o_cmd.load_byte = 1'b1;
                if (r_pad_first) begin
                    o_cmd.load_value = PAD_BYTE;
                end else if (r_last_block && i_status.fill_pos >= LEN_POS) begin
                    o_cmd.load_value = r_bits[63:56];
                end else begin
                    o_cmd.load_value = 8'h00;
                end
            end
            S_OUT: begin
                if (r_ovalid && i_ready && r_idx == 3'd7) begin
                    o_cmd.init_hash   = 1'b1;
                    o_cmd.clear_count = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_closing    <= 1'b0;
            r_last_block <= 1'b0;
            r_cnt        <= '0;
            r_ovalid     <= 1'b0;
            r_idx        <= '0;
            r_pad_first  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_closing <= i_data.end_of_message;
                        r_bits    <= {i_status.byte_count
                                      + {60'd0, i_data.has_data}, 3'b000};
                        if (i_data.has_data && i_status.fill_pos == 6'd63) begin
                            r_last_block <= 1'b0;
                            r_pad_first  <= i_data.end_of_message;
                            r_state <= S_LOAD;
                        end else if (i_data.end_of_message) begin
                            r_pad_first <= 1'b1;
                            r_last_block <= ((i_status.fill_pos
                                              + {5'd0, i_data.has_data}) < 6'd56)
                                            && !(i_data.has_data
                                                 && i_status.fill_pos == 6'd63);
                            r_state <= S_PAD;
                        end
                    end
                end
                S_LOAD: begin
                    r_cnt   <= '0;
                    r_state <= S_ROUND;
                end
                S_ROUND: begin
                    r_cnt <= r_cnt + 7'd1;
                    if (r_cnt == 7'(ROUNDS - 1)) r_state <= S_FINISH;
                end
                S_FINISH: begin
                    if (!r_closing) begin
                        r_state <= S_IDLE;
                    end else if (r_last_block && !r_pad_first) begin
                        r_idx   <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_last_block <= 1'b1;
                        r_state <= S_PAD;
                    end
                end
                S_PAD: begin
                    r_pad_first <= 1'b0;
                    if (r_last_block && i_status.fill_pos >= LEN_POS) begin
                        r_bits <= {r_bits[55:0], 8'h00};
                    end
                    if (i_status.fill_pos == 6'd63) r_state <= S_LOAD;
                end
                S_OUT: begin
                    if (!r_ovalid) begin
                        r_ovalid <= 1'b1;
                        r_word   <= i_status.hash_word;
                    end else if (i_ready) begin
                        r_ovalid <= 1'b0;
                        if (r_idx == 3'd7) begin
                            r_closing <= 1'b0;
                            r_state   <= S_IDLE;
                        end else begin
                            r_idx <= r_idx + 3'd1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid            = r_ovalid;
    assign o_data.digest_word = r_word;
    assign o_data.word_index  = r_idx;
    assign o_data.last_word   = (r_idx == 3'd7);

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !o_valid) else $error("ready while output pending");
    a_rounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH) |-> $past(r_state == S_ROUND))
        else $error("finish without rounds");
    a_out_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_state == S_OUT) else $error("output outside out state");
endmodule

// File: rtl/sha256_message_hasher.sv
// Top level: SHA-256 message hasher, byte in, eight digest words out.
//  channel | dir | payload                                  | handshake
//  in      | in  | data_byte, has_data, end_of_message       | i_valid / o_ready
//  out     | out | digest_word, word_index, last_word        | o_valid / i_ready
// A byte that does not fill a block or end the message is stored; o_ready stays high.
// A filled block is compressed: load, 64 rounds on one shared round unit, hash update.
// Closing: pad bytes one a cycle into the buffer, one or two compressions, then
// eight output beats of registered words. Synchronous active-low reset; no item is
// taken while a block or digest is in work; output stalls hold the beat.
module sha256_message_hasher (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  sha256_pkg::t_in_beat  i_data,
    output logic                  o_valid,
    input  logic                  i_ready,
    output sha256_pkg::t_out_beat o_data
);
    import sha256_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    sha256_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_data(i_data),
        .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data),
        .o_cmd(cmd), .i_status(status)
    );

    sha256_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd(cmd), .o_status(status)
    );
endmodule
